/* rtl/core/sql_like_pattern_matcher_macros.svh */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher assertion macros
// Shared concurrent assertion forms used by the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef SQL_LIKE_PATTERN_MATCHER_MACROS_SVH
`define SQL_LIKE_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slpm_pkg.sv */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher package
// Capacity constants, request codes, the queued command type and the
// wildcard closure function shared by the matcher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slpm_pkg;

    // Pattern capacity and derived widths.
    localparam int MAX_PATTERN  = 32;
    localparam int POS_W        = MAX_PATTERN + 1;
    localparam int CNT_W        = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CLOSE_LEVELS = $clog2(POS_W);

    // Command queue sizing.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Request operation codes.
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_SUBJECT = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;

    // Wildcard characters.
    localparam logic [7:0] CHAR_ANY_RUN = 8'h25;
    localparam logic [7:0] CHAR_ANY_ONE = 8'h5F;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic       start_new;
        logic       is_run;
        logic       is_one;
    } slpm_cmd_t;

    // Adds every position reachable through a chain of '%' bytes taking an
    // empty run. link[i] set means position i follows from position i-1.
    // This is a parallel prefix (carry lookahead) over the position set.
    function automatic logic [POS_W-1:0] close_positions(
        input logic [POS_W-1:0] seed,
        input logic [POS_W-1:0] link
    );
        logic [POS_W-1:0] gen;
        logic [POS_W-1:0] prop;
        logic [POS_W-1:0] gen_n;
        logic [POS_W-1:0] prop_n;
        int               span;
        gen  = seed;
        prop = link;
        for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++)
        begin
            span   = 1 << lvl;
            gen_n  = gen;
            prop_n = prop;
            for (int i = 0; i < POS_W; i++)
            begin
                if (i >= span)
                begin
                    gen_n[i]  = gen[i] | (prop[i] & gen[i - span]);
                    prop_n[i] = prop[i] & prop[i - span];
                end
            end
            gen  = gen_n;
            prop = prop_n;
        end
        return gen;
    endfunction

endpackage

/* rtl/core/slpm_front.sv */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher front end
// Accepts requests, drops unused operation codes and classifies each byte
// as a wildcard or a literal before it enters the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slpm_front
    import slpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] char_value,
    input  logic       first,
    output logic       push_valid,
    input  logic       push_ready,
    output slpm_cmd_t  push_cmd
);

    // Whether any request has been taken since reset, kept as a status flag for debug visibility.
    logic seen_reg;
    logic seen_next;

    // The front takes a request whenever the queue has room.
    assign in_ready = push_ready;

    // Only the three defined operations are queued; the rest vanish.
    always_comb
    begin
        case (operation)
            OP_PATTERN, OP_SUBJECT, OP_END: push_valid = in_valid;
            default:                        push_valid = 1'b0;
        endcase
    end

    // Classify the byte once so the back end compares only literals.
    always_comb
    begin
        push_cmd.kind       = operation;
        push_cmd.char_value = char_value;
        push_cmd.start_new  = first && (operation == OP_PATTERN);
        push_cmd.is_run     = (char_value == CHAR_ANY_RUN);
        push_cmd.is_one     = (char_value == CHAR_ANY_ONE);
    end

    // Remember that traffic has been taken since reset.
    assign seen_next = seen_reg | (in_valid & in_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

/* rtl/core/slpm_queue.sv */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher command queue
// A short first-in first-out buffer that decouples the front end from the
// execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slpm_queue
    import slpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  slpm_cmd_t push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output slpm_cmd_t pop_cmd
);

    slpm_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg;
    logic [QFILL_W-1:0] fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/slpm_back.sv */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher back end
// Holds the pattern, advances the position set one subject byte per cycle
// and registers the match result for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sql_like_pattern_matcher_macros.svh"

module slpm_back
    import slpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  slpm_cmd_t pop_cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      matched,
    output logic      pattern_overflow
);

    // Pattern storage: byte and its wildcard class per position.
    logic [7:0]       pat_byte_mem [MAX_PATTERN];
    logic             pat_run_mem  [MAX_PATTERN];
    logic             pat_one_mem  [MAX_PATTERN];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [POS_W-1:0] act_reg;
    logic [POS_W-1:0] act_next;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] start_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             matched_next;
    logic             out_ovf_reg;
    logic             out_ovf_next;

    logic             exec;
    logic [CNT_W-1:0] base_count;
    logic [POS_W-1:0] base_start;
    logic             room;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [POS_W-1:0] link;
    logic [POS_W-1:0] stepped;

    // Only an end-of-subject request needs the output register free.
    assign pop_ready = (pop_cmd.kind != OP_END) || !out_valid_reg || out_ready;
    assign exec      = pop_valid && pop_ready;

    // Pattern append: restart on a new pattern, drop bytes past capacity.
    assign base_count = pop_cmd.start_new ? '0 : count_reg;
    assign base_start = pop_cmd.start_new ? POS_W'(1) : start_reg;
    assign room       = (base_count < CNT_W'(MAX_PATTERN));
    assign wr_en      = exec && (pop_cmd.kind == OP_PATTERN) && room;
    assign wr_idx     = base_count[IDX_W-1:0];

    // Closed start set: it grows while the pattern begins with '%' bytes.
    always_comb
    begin
        start_next = base_start;
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            if (room && pop_cmd.is_run && base_start[p] && (base_count == CNT_W'(p)))
            begin
                start_next[p + 1] = 1'b1;
            end
        end
    end

    // One subject byte: literal or '_' moves on, '%' stays, then close.
    always_comb
    begin
        link    = '0;
        stepped = '0;
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            if (CNT_W'(p) < count_reg)
            begin
                link[p + 1] = pat_run_mem[p];
                if (act_reg[p] && pat_run_mem[p])
                begin
                    stepped[p] = 1'b1;
                end
                if (act_reg[p] && !pat_run_mem[p]
                    && (pat_one_mem[p] || (pat_byte_mem[p] == pop_cmd.char_value)))
                begin
                    stepped[p + 1] = 1'b1;
                end
            end
        end
    end

    // Execute one queued request.
    always_comb
    begin
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        out_ovf_next   = out_ovf_reg;
        if (exec)
        begin
            case (pop_cmd.kind)
                OP_PATTERN:
                begin
                    count_next    = room ? base_count + CNT_W'(1) : base_count;
                    overflow_next = (pop_cmd.start_new ? 1'b0 : overflow_reg) | !room;
                    act_next      = start_next;
                end
                OP_SUBJECT:
                begin
                    act_next = close_positions(stepped, link);
                end
                OP_END:
                begin
                    out_valid_next = 1'b1;
                    matched_next   = act_reg[count_reg] && !overflow_reg;
                    out_ovf_next   = overflow_reg;
                    act_next       = start_reg;
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            act_reg       <= POS_W'(1);
            start_reg     <= POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            act_reg       <= act_next;
            if (exec && (pop_cmd.kind == OP_PATTERN))
            begin
                start_reg <= start_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and pattern storage carry no reset.
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        out_ovf_reg <= out_ovf_next;
        if (wr_en)
        begin
            pat_byte_mem[wr_idx] <= pop_cmd.char_value;
            pat_run_mem[wr_idx]  <= pop_cmd.is_run;
            pat_one_mem[wr_idx]  <= pop_cmd.is_one;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = out_ovf_reg;

    // Consistency checks on the matcher state.
    `SLPM_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_PATTERN), "pattern count exceeds capacity")
    `SLPM_ASSERT_NOW(a_start_has_origin, clk, rst_n, 1'b1, start_reg[0], "start set lost its origin position")
    `SLPM_ASSERT_NOW(a_overflow_no_match, clk, rst_n, out_valid_reg && out_ovf_reg, !matched_reg, "match reported on an overflowed pattern")
    `SLPM_ASSERT_NEXT(a_pattern_resets_set, clk, rst_n, exec && (pop_cmd.kind == OP_PATTERN), act_reg == start_reg, "position set not restarted after a pattern byte")

endmodule

/* rtl/core/sql_like_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// SQL LIKE pattern matcher
// Matches a streamed subject against a loaded LIKE pattern with '%' and '_'.
// ----------------------------------------------------------------------------
// Load a pattern one byte per request (first marks the start of a new one),
// then stream subject bytes and finish with an end-of-subject request, which
// returns matched and pattern_overflow. The block takes one request every
// cycle while its queue has room: each subject byte updates the whole
// position set at once (one comparator per pattern position followed by a
// prefix network that resolves runs of '%'). A result appears in the cycle
// after its end-of-subject request is taken from the queue; the two-entry
// command queue lets requests keep arriving while a result waits on the
// output, and input stalls only once that queue is full behind an untaken
// result. Patterns longer than 32 bytes are flagged and never match.
`timescale 1ns / 1ps

module sql_like_pattern_matcher
    import slpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] char_value,
    input  logic       first,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);

    logic      push_valid;
    logic      push_ready;
    slpm_cmd_t push_cmd;
    logic      pop_valid;
    logic      pop_ready;
    slpm_cmd_t pop_cmd;

    // Request intake and classification.
    slpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .char_value (char_value),
        .first      (first),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decoupling queue.
    slpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Pattern store, position set and result register.
    slpm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_cmd          (pop_cmd),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

endmodule
